// ===== design/teq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_pkg
// shared types, constants and the saturating add of the timer expiry queue
// ----------------------------------------------------------------------------
package teq_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int ID_W       = 6;
   localparam int TIME_W     = 48;
   localparam int TMO_W      = 32;
   localparam int CAP_W      = 7;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_RESTART = 2'd1,
      OP_STOP    = 2'd2,
      OP_TICK    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ONESHOT = 2'd0,
      KIND_REPEAT  = 2'd1,
      KIND_VOLATILE = 2'd2,
      KIND_BAD     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNCONF  = 2'd1,
      ST_BADKIND = 2'd2,
      ST_ZEROREP = 2'd3
   } status_type;

   // one timer table entry
   typedef struct packed {
      logic [TIME_W-1:0] expiry;
      logic [TMO_W-1:0]  period;
      logic [1:0]        kind;
      logic              armed;
      logic              configured;
   } entry_type;

   // table write request from the sequencer
   typedef struct packed {
      logic              en;
      logic [ID_W-1:0]   addr;
      entry_type         data;
   } wr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_CMD_RD,
      S_CMD_WR,
      S_SCAN,
      S_SCAN_END,
      S_FIRE_RD,
      S_FIRE_WR,
      S_OUT
   } state_type;

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TMO_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {{(TIME_W-TMO_W+1){1'b0}}, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

endpackage

// ===== design/teq_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teq_table
// timer entry memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module teq_table (
   input  logic                       clock,
   input  logic [teq_pkg::ID_W-1:0]   rd_addr,
   output teq_pkg::entry_type         rd_data,
   input  teq_pkg::wr_type            wr
);
   import teq_pkg::*;

   entry_type mem_ff [SLOT_COUNT];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== design/timer_expiry_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_expiry_queue_unit
// 64-slot timer table with command handling and ordered expiry on tick
// ----------------------------------------------------------------------------
// One beat at a time. After reset a clearing pass over all 64 slots zeroes
// the timer memory while req_tready stays low. Start, restart and stop pass
// through a read state and a write state and give one acknowledgement beat,
// registered from the write state. A tick scans the whole table through the
// single memory read port for each fire, then does a read-modify-write of
// the fired entry and the output beat. The memory port sets the pace. The
// result beat is held in a register; the block waits for it to be taken
// before it writes the next beat.
// ----------------------------------------------------------------------------
module timer_expiry_queue_unit (
   input  logic         clock,
   input  logic         reset,
   // tdata: op[1:0], timer_id[7:2], timeout_us[39:8], timer_kind[41:40],
   //        start_at[89:42], now_us[137:90], zero fill to 144
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,
   // tdata: fired_id[5:0], fired_at[53:6], status[55:54], zero fill to 56
   // tuser: event_kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [6:0]   csr_wdata
);
   import teq_pkg::*;

   // request field unpack
   logic [1:0]        f_op;
   logic [ID_W-1:0]   f_id;
   logic [TMO_W-1:0]  f_tmo;
   logic [1:0]        f_kind;
   logic [TIME_W-1:0] f_at;
   logic [TIME_W-1:0] f_now;
   assign f_op   = req_tdata[1:0];
   assign f_id   = req_tdata[7:2];
   assign f_tmo  = req_tdata[39:8];
   assign f_kind = req_tdata[41:40];
   assign f_at   = req_tdata[89:42];
   assign f_now  = req_tdata[137:90];

   state_type         state_ff, state_in;
   logic [CAP_W-1:0]  cap_ff;
   logic [TIME_W-1:0] now_ff, now_in;
   // latched command
   logic [1:0]        op_ff, op_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [TMO_W-1:0]  tmo_ff, tmo_in;
   logic [1:0]        kind_ff, kind_in;
   logic [TIME_W-1:0] at_ff, at_in;
   // scan state
   logic [ID_W:0]     cnt_ff, cnt_in;      // read address counter, wide for end
   logic [ID_W:0]     rcnt_ff, rcnt_in;    // address of data now on read port
   logic              found_ff, found_in;
   logic [ID_W-1:0]   best_ff, best_in;
   logic [TIME_W-1:0] best_t_ff, best_t_in;
   logic [CAP_W-1:0]  fires_ff, fires_in;
   // output register
   logic              ov_ff, ov_in;
   logic              oev_ff, oev_in;
   logic [ID_W-1:0]   oid_ff, oid_in;
   logic [TIME_W-1:0] oat_ff, oat_in;
   logic [1:0]        ost_ff, ost_in;
   logic              olast_ff, olast_in;
   logic              ret_scan_ff, ret_scan_in;  // rescan after beat leaves

   logic [ID_W-1:0]   rd_addr;
   entry_type         rd_data;
   wr_type            wr;
   entry_type         e;
   logic [CAP_W-1:0]  cap_eff;

   teq_table u_table (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (wr)
   );

   // zero acts as one, above slot count acts as slot count
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (cap_ff > CAP_W'(SLOT_COUNT)) begin
         cap_eff = CAP_W'(SLOT_COUNT);
      end else begin
         cap_eff = cap_ff;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {ost_ff, oat_ff, oid_ff};
   assign rsp_tuser  = oev_ff;
   assign rsp_tlast  = olast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cap_ff   <= CAP_W'(SLOT_COUNT);
         now_ff   <= '0;
         cnt_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cap_ff   <= csr_we ? csr_wdata : cap_ff;
         now_ff   <= now_in;
         cnt_ff   <= cnt_in;
         ov_ff    <= ov_in;
      end
      op_ff <= op_in; id_ff <= id_in; tmo_ff <= tmo_in; kind_ff <= kind_in;
      at_ff <= at_in; rcnt_ff <= rcnt_in; found_ff <= found_in;
      best_ff <= best_in; best_t_ff <= best_t_in; fires_ff <= fires_in;
      oev_ff <= oev_in; oid_ff <= oid_in; oat_ff <= oat_in; ost_ff <= ost_in;
      olast_ff <= olast_in; ret_scan_ff <= ret_scan_in;
   end

   always_comb begin
      state_in = state_ff;
      now_in = now_ff;
      op_in = op_ff; id_in = id_ff; tmo_in = tmo_ff; kind_in = kind_ff;
      at_in = at_ff;
      cnt_in = cnt_ff; rcnt_in = rcnt_ff; found_in = found_ff;
      best_in = best_ff; best_t_in = best_t_ff; fires_in = fires_ff;
      ov_in = ov_ff; oev_in = oev_ff; oid_in = oid_ff; oat_in = oat_ff;
      ost_in = ost_ff; olast_in = olast_ff; ret_scan_in = ret_scan_ff;
      rd_addr = id_ff;
      wr = '0;
      e = rd_data;
      if (ov_ff && rsp_tready) begin
         ov_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            wr.en   = 1'b1;
            wr.addr = cnt_ff[ID_W-1:0];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == (ID_W+1)'(SLOT_COUNT-1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in = f_op; id_in = f_id; tmo_in = f_tmo; kind_in = f_kind;
               at_in = f_at;
               if (op_type'(f_op) == OP_TICK) begin
                  now_in   = f_now;
                  fires_in = '0;
                  cnt_in   = '0;
                  found_in = 1'b0;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_CMD_RD;
               end
            end
         end
         S_CMD_RD: begin
            rd_addr  = id_ff;
            state_in = S_CMD_WR;
         end
         S_CMD_WR: begin
            if (!ov_ff) begin
               oev_in = 1'b0; oid_in = id_ff; oat_in = '0; olast_in = 1'b1;
               ost_in = ST_OK;
               wr.addr = id_ff;
               if (op_type'(op_ff) == OP_START) begin
                  if (kind_type'(kind_ff) == KIND_BAD) begin
                     ost_in = ST_BADKIND;
                  end else if (kind_type'(kind_ff) == KIND_REPEAT && tmo_ff == '0) begin
                     ost_in = ST_ZEROREP;
                  end else begin
                     e.period = tmo_ff; e.kind = kind_ff;
                     e.configured = 1'b1; e.armed = 1'b1;
                     e.expiry = (at_ff != '0) ? at_ff : sat_add(now_ff, tmo_ff);
                     wr.en = 1'b1;
                  end
               end else if (!rd_data.configured) begin
                  ost_in = ST_UNCONF;
               end else if (op_type'(op_ff) == OP_RESTART) begin
                  e.armed = 1'b1;
                  e.expiry = sat_add(now_ff, rd_data.period);
                  wr.en = 1'b1;
               end else begin
                  e.armed = 1'b0;
                  e.expiry = '0;
                  wr.en = 1'b1;
               end
               wr.data  = e;
               ov_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            // read address cnt, compare the registered data of address rcnt
            rd_addr = cnt_ff[ID_W-1:0];
            rcnt_in = cnt_ff;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               if (rd_data.armed && rd_data.expiry <= now_ff &&
                   (!found_ff || rd_data.expiry < best_t_ff)) begin
                  found_in  = 1'b1;
                  best_in   = rcnt_ff[ID_W-1:0];
                  best_t_in = rd_data.expiry;
               end
            end
            if (cnt_ff == (ID_W+1)'(SLOT_COUNT-1)) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            if (rd_data.armed && rd_data.expiry <= now_ff &&
                (!found_ff || rd_data.expiry < best_t_ff)) begin
               found_in  = 1'b1;
               best_in   = rcnt_ff[ID_W-1:0];
               best_t_in = rd_data.expiry;
            end
            state_in = S_FIRE_RD;
         end
         S_FIRE_RD: begin
            rd_addr = best_ff;
            if (!found_ff) begin
               if (fires_ff == '0) begin
                  // nothing due: plain acknowledgement
                  state_in = S_OUT;
                  ret_scan_in = 1'b0;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_FIRE_WR;
            end
         end
         S_FIRE_WR: begin
            wr.en   = 1'b1;
            wr.addr = best_ff;
            if (kind_type'(rd_data.kind) == KIND_REPEAT) begin
               e.expiry = sat_add(rd_data.expiry, rd_data.period);
            end else begin
               e.armed = 1'b0;
               if (kind_type'(rd_data.kind) == KIND_VOLATILE) begin
                  e.configured = 1'b0;
               end
            end
            wr.data  = e;
            fires_in = fires_ff + 1'b1;
            ret_scan_in = ((fires_ff + 1'b1) != cap_eff);
            state_in = S_OUT;
         end
         S_OUT: begin
            // the fire beat's last flag waits on the next scan, so a fire
            // is stashed in the output register until we know whether another follows
            if (!ov_ff || rsp_tready) begin
               if (!found_ff) begin
                  oev_in = 1'b0; oid_in = '0; oat_in = '0; ost_in = ST_OK;
                  olast_in = 1'b1; ov_in = 1'b1;
                  state_in = S_IDLE;
               end else if (ret_scan_ff) begin
                  state_in = S_SCAN;
                  cnt_in = '0;
                  found_in = 1'b0;
                  // stash fired entry; emitted once the next scan ends
                  oid_in = best_ff; oat_in = best_t_ff;
               end else begin
                  oev_in = 1'b1; oid_in = best_ff; oat_in = best_t_ff;
                  ost_in = ST_OK; olast_in = 1'b1; ov_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      // pending fire from an earlier scan goes out when the new scan ends
      if (state_ff == S_FIRE_RD && fires_ff != '0) begin
         if (found_ff) begin
            if (ov_ff && !rsp_tready) begin
               state_in = S_FIRE_RD;
            end else begin
               oev_in = 1'b1; ost_in = ST_OK; olast_in = 1'b0; ov_in = 1'b1;
               oid_in = oid_ff; oat_in = oat_ff;
            end
         end else begin
            if (ov_ff && !rsp_tready) begin
               state_in = S_FIRE_RD;
            end else begin
               oev_in = 1'b1; ost_in = ST_OK; olast_in = 1'b1; ov_in = 1'b1;
            end
         end
      end
   end

endmodule

// ===== bench/timer_expiry_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_expiry_queue_unit_tb
// self-checking bench for the timer expiry queue
// ----------------------------------------------------------------------------
// Drives start, restart, stop and tick commands on the request stream and
// checks every response beat against a behavioral timer table kept in a
// scoreboard class. Runs through several fire caps and idle/stall mixes.
// ----------------------------------------------------------------------------
module timer_expiry_queue_unit_tb;
   import teq_pkg::*;

   // one expected or observed response beat
   typedef struct {
      logic              ev;
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] at;
      logic [1:0]        st;
      logic              lst;
   } beat_type;

   // timer table model plus queue of pending response beats
   class timer_scoreboard;
      logic [TIME_W-1:0] exp_at [SLOT_COUNT];
      logic [TMO_W-1:0]  per    [SLOT_COUNT];
      logic [1:0]        knd    [SLOT_COUNT];
      bit                arm    [SLOT_COUNT];
      bit                cfgd   [SLOT_COUNT];
      logic [TIME_W-1:0] clock_now;
      logic [CAP_W-1:0]  fire_cap;
      beat_type          pending[$];
      int                errors;
      int                fires;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            exp_at[i] = '0; per[i] = '0; knd[i] = '0; arm[i] = 0; cfgd[i] = 0;
         end
         clock_now = '0;
         fire_cap = 7'd64;
         errors = 0;
         fires = 0;
      endfunction

      function logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [TMO_W-1:0] b);
         logic [TIME_W:0] s;
         s = {1'b0, a} + {{(TIME_W-TMO_W+1){1'b0}}, b};
         return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
      endfunction

      function void push(logic ev, logic [ID_W-1:0] id, logic [TIME_W-1:0] at,
                         logic [1:0] st, logic lst);
         beat_type b;
         b.ev = ev; b.id = id; b.at = at; b.st = st; b.lst = lst;
         pending.push_back(b);
      endfunction

      // note an accepted command and work out its response beats
      function void note_command(op_type op, logic [ID_W-1:0] id, logic [TMO_W-1:0] tmo,
                                 logic [1:0] kind, logic [TIME_W-1:0] at,
                                 logic [TIME_W-1:0] now);
         int cap, n, best;
         logic [1:0] st;
         if (op == OP_TICK) begin
            cap = (fire_cap == 0) ? 1 : (fire_cap > 64 ? 64 : int'(fire_cap));
            clock_now = now;
            n = 0;
            while (n < cap) begin
               best = -1;
               for (int i = 0; i < SLOT_COUNT; i++)
                  if (arm[i] && exp_at[i] <= clock_now &&
                      (best < 0 || exp_at[i] < exp_at[best]))
                     best = i;
               if (best < 0) break;
               push(1'b1, best[ID_W-1:0], exp_at[best], ST_OK, 1'b0);
               n++;
               fires++;
               if (knd[best] == KIND_REPEAT)
                  exp_at[best] = add_sat(exp_at[best], per[best]);
               else begin
                  arm[best] = 0;
                  if (knd[best] == KIND_VOLATILE) cfgd[best] = 0;
               end
            end
            if (n == 0) push(1'b0, '0, '0, ST_OK, 1'b1);
            else pending[pending.size()-1].lst = 1'b1;
            return;
         end
         st = ST_OK;
         if (op == OP_START) begin
            if (kind == KIND_BAD) st = ST_BADKIND;
            else if (kind == KIND_REPEAT && tmo == 0) st = ST_ZEROREP;
            else begin
               per[id] = tmo; knd[id] = kind; cfgd[id] = 1; arm[id] = 1;
               exp_at[id] = (at != 0) ? at : add_sat(clock_now, tmo);
            end
         end else if (!cfgd[id]) st = ST_UNCONF;
         else if (op == OP_RESTART) begin
            arm[id] = 1;
            exp_at[id] = add_sat(clock_now, per[id]);
         end else begin
            arm[id] = 0;
            exp_at[id] = '0;
         end
         push(1'b0, id, '0, st, 1'b1);
      endfunction

      // compare one observed response beat with the oldest expectation
      function void check_response(beat_type got);
         beat_type want;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected beat: ev=%0d id=%0d at=%0h st=%0d last=%0d",
                        got.ev, got.id, got.at, got.st, got.lst);
            return;
         end
         want = pending.pop_front();
         if (got.ev !== want.ev || got.id !== want.id || got.at !== want.at ||
             got.st !== want.st || got.lst !== want.lst) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: exp ev=%0d id=%0d at=%0h st=%0d last=%0d",
                         " / got ev=%0d id=%0d at=%0h st=%0d last=%0d"},
                        want.ev, want.id, want.at, want.st, want.lst,
                        got.ev, got.id, got.at, got.st, got.lst);
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [55:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 0;
   logic [6:0]   csr_wdata = '0;

   timer_scoreboard board = new();
   int  send_idle_pct = 0;      // sender gap chance per cycle
   int  stall_pct = 0;          // receiver stall chance per cycle
   int  quiet_cycles = 0;       // watchdog: cycles with no beat moved
   int  sent = 0;
   int  pass_ids[$];            // slots the random part concentrates on
   localparam int WATCHDOG = 20000;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   timer_expiry_queue_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // receiver: random stalls, check each response beat taken
   always @(posedge clock) begin
      beat_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ev = rsp_tuser; got.id = rsp_tdata[5:0]; got.at = rsp_tdata[53:6];
         got.st = rsp_tdata[55:54]; got.lst = rsp_tlast;
         board.check_response(got);
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("timeout: no beat moved for %0d cycles", WATCHDOG);
         $display("FAIL");
         $finish;
      end
   end

   // send one command beat, with an optional idle gap before it
   task automatic send_cmd(op_type op, logic [ID_W-1:0] id, logic [TMO_W-1:0] tmo,
                           logic [1:0] kind, logic [TIME_W-1:0] at,
                           logic [TIME_W-1:0] now);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, now, at, kind, tmo, id, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_command(op, id, tmo, kind, at, now);
      sent++;
   endtask

   // wait for all responses, then a short settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // cap register is only touched while the block is idle
   task automatic write_cap(logic [6:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      board.fire_cap = v;
   endtask

   function automatic logic [TIME_W-1:0] rand_time();
      logic [63:0] r;
      r = {$urandom(), $urandom()};
      return r[TIME_W-1:0];
   endfunction

   // random phase: start, restart, stop and tick commands, mostly well-formed and mostly on a few slots
   task automatic random_phase(int count);
      op_type op;
      logic [ID_W-1:0] id;
      logic [1:0] kind;
      logic [TMO_W-1:0] tmo;
      logic [TIME_W-1:0] at;
      for (int k = 0; k < count; k++) begin
         id   = ($urandom_range(3) == 0) ? ID_W'($urandom_range(63)) :
                ID_W'(pass_ids[$urandom_range(pass_ids.size()-1)]);
         op   = ($urandom_range(9) < 3) ? OP_TICK : op_type'($urandom_range(2));
         kind = ($urandom_range(15) == 0) ? KIND_BAD : 2'($urandom_range(2));
         tmo  = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(200);
         if ($urandom_range(15) == 0) tmo = 0;
         at   = ($urandom_range(2) == 0) ?
                board.clock_now + TIME_W'($urandom_range(300)) : '0;
         if ($urandom_range(19) == 0) at = rand_time();
         if (op == OP_TICK)
            send_cmd(op, id, $urandom(), 2'($urandom_range(3)), rand_time(),
                     ($urandom_range(19) == 0) ? rand_time()
                        : board.clock_now + TIME_W'($urandom_range(150)));
         else
            send_cmd(op, id, tmo, kind, at, rand_time());
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) pass_ids.push_back($urandom_range(63));
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every op, every status, extreme fields
      send_cmd(OP_RESTART, 6'd5, '0, KIND_ONESHOT, '0, '0);             // unconfigured
      send_cmd(OP_STOP, 6'd63, '1, KIND_BAD, '1, '1);                   // unconfigured
      send_cmd(OP_START, 6'd1, 32'd10, KIND_BAD, '0, '0);               // bad kind
      send_cmd(OP_START, 6'd2, '0, KIND_REPEAT, '0, '0);                // zero repeat
      send_cmd(OP_TICK, '0, '0, KIND_ONESHOT, '0, '0);                  // nothing due
      send_cmd(OP_START, 6'd0, 32'd5, KIND_ONESHOT, '0, '0);
      send_cmd(OP_START, 6'd63, 32'd3, KIND_REPEAT, 48'd5, '0);         // tie with slot 0
      send_cmd(OP_START, 6'd7, 32'd1, KIND_VOLATILE, 48'd4, '0);
      send_cmd(OP_START, 6'd9, 32'd1, KIND_ONESHOT, '0, '0);
      send_cmd(OP_START, 6'd9, 32'd2, KIND_ONESHOT, '0, '0);            // re-arm armed slot
      send_cmd(OP_STOP, 6'd9, '0, KIND_ONESHOT, '0, '0);
      send_cmd(OP_TICK, '0, '0, KIND_ONESHOT, '0, 48'd12);              // repeat fires again
      send_cmd(OP_RESTART, 6'd7, '0, KIND_ONESHOT, '0, '0);             // volatile gone
      send_cmd(OP_RESTART, 6'd0, '0, KIND_ONESHOT, '0, '0);
      send_cmd(OP_START, 6'd20, '1, KIND_ONESHOT, '1, '0);
      send_cmd(OP_START, 6'd21, '1, KIND_REPEAT, 48'hFFFF_FFFF_FFF0, '0); // saturates
      send_cmd(OP_TICK, '0, '0, KIND_ONESHOT, '0, '1);
      send_cmd(OP_STOP, 6'd21, '0, KIND_ONESHOT, '0, '0);
      send_cmd(OP_STOP, 6'd63, '0, KIND_ONESHOT, '0, '0);
      send_cmd(OP_TICK, '0, '0, KIND_ONESHOT, '0, '0);                  // time back to zero

      // random phases across idle mixes and fire caps, extremes included
      write_cap(7'd1);
      random_phase(80);
      send_idle_pct = 53;
      write_cap(7'd0);
      random_phase(70);
      drain();                      // sender holds off until all responses are in
      send_idle_pct = 0; stall_pct = 53;
      write_cap(7'd127);
      random_phase(80);
      send_idle_pct = 30; stall_pct = 30;
      write_cap(7'd3);
      random_phase(70);
      send_idle_pct = 0; stall_pct = 0;
      write_cap(7'd64);
      random_phase(50);
      drain();

      $display("covered %0d commands, %0d timer fires, caps 0/1/3/64/127",
               sent, board.fires);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASS");
      else begin
         $display("%0d mismatches, %0d beats missing", board.errors, board.pending.size());
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ===== timer_expiry_queue_unit.f =====
design/teq_pkg.sv
design/teq_table.sv
design/timer_expiry_queue_unit.sv
bench/timer_expiry_queue_unit_tb.sv
